### hdl/ndjp_pkg.sv
// Shared constants and types for the NDJSON row partitioner.
`default_nettype none
package ndjp_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int OUT_BITS       = 32;
  localparam int CFG_BITS       = 32;
  localparam int CFG_IDX_BITS   = 1;
  localparam int EVQ_DEPTH      = 4;
  localparam int RESQ_DEPTH     = 2;

  localparam logic [7:0]              NEWLINE_BYTE    = 8'd10;
  localparam logic [CFG_BITS-1:0]     MIN_TARGET      = 32'h0001_0000;
  localparam logic [CFG_BITS-1:0]     TARGET_RESET    = 32'h0001_0000;
  localparam logic [CFG_BITS-1:0]     ROW_FLOOR_RESET = 32'd1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_GOAL = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_FLOOR = 1'b1;

  typedef struct packed {
    logic [OUT_BITS-1:0] part_offset;
    logic [OUT_BITS-1:0] part_length;
    logic [OUT_BITS-1:0] first_row;
    logic [OUT_BITS-1:0] end_row;
    logic                final_part;
  } part_res_t;

endpackage
`default_nettype wire

### hdl/ndjp_fifo.sv
// Small first-word-fall-through queue of words.
`default_nettype none
module ndjp_fifo
  import ndjp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic [AW:0]      count_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

### hdl/ndjp_front.sv
// Front end: takes bytes, counts offset and rows, queues row-end events.
`default_nettype none
module ndjp_front
  import ndjp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_buffer,
  output logic                         ev_push,
  input  wire logic                    ev_full,
  output logic [2*COUNT_BITS:0]        ev_word
);

  logic [COUNT_BITS-1:0] byte_position;
  logic [COUNT_BITS-1:0] current_row;
  logic [COUNT_BITS-1:0] pos_end;
  logic [COUNT_BITS-1:0] row_end_idx;
  logic                  accept;
  logic                  row_end;

  assign full        = ev_full;
  assign accept      = push && !ev_full;
  assign row_end     = (data_byte == NEWLINE_BYTE) || end_of_buffer;
  assign pos_end     = (&byte_position) ? byte_position : byte_position + 1'b1;
  assign row_end_idx = (&current_row) ? current_row : current_row + 1'b1;
  assign ev_push     = accept && row_end;
  assign ev_word     = {end_of_buffer, row_end_idx, pos_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      current_row   <= '0;
    end else if (accept) begin
      if (end_of_buffer) begin
        byte_position <= '0;
        current_row   <= '0;
      end else begin
        byte_position <= pos_end;
        if (row_end) begin
          current_row <= row_end_idx;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ndjp_back.sv
// Back end: holds config and the open partition, decides closes, builds results.
`default_nettype none
module ndjp_back
  import ndjp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  input  wire logic                    ev_empty,
  input  wire logic [2*COUNT_BITS:0]   ev_word,
  output logic                         ev_pop,
  input  wire logic                    res_full,
  output logic                         res_push,
  output part_res_t                    res_word
);

  localparam int CW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam int XW = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  logic [CFG_BITS-1:0]   size_goal;
  logic [CFG_BITS-1:0]   row_floor;
  logic [COUNT_BITS-1:0] open_off;
  logic [COUNT_BITS-1:0] open_row;

  logic [COUNT_BITS-1:0] ev_pos;
  logic [COUNT_BITS-1:0] ev_row;
  logic                  ev_last;
  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] rows;
  logic [CFG_BITS-1:0]   tgt;
  logic [CFG_BITS-1:0]   mnr;
  logic                  hit;
  logic [XW-1:0]         x_off;
  logic [XW-1:0]         x_len;
  logic [XW-1:0]         x_first;
  logic [XW-1:0]         x_end;

  assign ev_pos  = ev_word[COUNT_BITS-1:0];
  assign ev_row  = ev_word[2*COUNT_BITS-1:COUNT_BITS];
  assign ev_last = ev_word[2*COUNT_BITS];

  assign len  = ev_pos - open_off;
  assign rows = ev_row - open_row;
  assign tgt  = (size_goal < MIN_TARGET) ? MIN_TARGET : size_goal;
  assign mnr  = (row_floor == '0) ? CFG_BITS'(1) : row_floor;
  assign hit  = (CW'(len) >= CW'(tgt)) && (CW'(rows) >= CW'(mnr));

  assign ev_pop   = !ev_empty && !res_full;
  assign res_push = ev_pop && (hit || ev_last);

  assign x_off   = XW'(open_off);
  assign x_len   = XW'(len);
  assign x_first = XW'(open_row);
  assign x_end   = XW'(ev_row);

  always_comb begin
    res_word.part_offset = x_off[OUT_BITS-1:0];
    res_word.part_length = x_len[OUT_BITS-1:0];
    res_word.first_row   = x_first[OUT_BITS-1:0];
    res_word.end_row     = x_end[OUT_BITS-1:0];
    res_word.final_part  = ev_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_goal <= TARGET_RESET;
      row_floor <= ROW_FLOOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SIZE_GOAL: size_goal <= cfg_data;
        CFG_ROW_FLOOR: row_floor <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_off <= '0;
      open_row <= '0;
    end else if (ev_pop) begin
      if (ev_last) begin
        open_off <= '0;
        open_row <= '0;
      end else if (hit) begin
        open_off <= ev_pos;
        open_row <= ev_row;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed into a full queue");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (res_push && ev_last) |=> (open_off == '0) && (open_row == '0))
    else $error("open partition not cleared after final part");

  a_close_moves: assert property (@(posedge clk) disable iff (rst)
    (res_push && !ev_last) |=> (open_off == $past(ev_pos)) && (open_row == $past(ev_row)))
    else $error("open partition did not advance on close");
`endif

endmodule
`default_nettype wire

### hdl/ndjson_row_partitioner.sv
// Top level of the NDJSON row partitioner.
//
//   channel   ports                                        handshake
//   bytes     data_byte, end_of_buffer                     push / full
//   parts     part_offset, part_length, first_row,
//             end_row, final_part                          pop / empty
//   config    cfg_index, cfg_data                          cfg_write
//
// One byte per cycle sustained while full is low; each byte is a counter update in the front end.
// A closing byte's part word clears empty once it has passed the row-end queue and then the part queue.
// rst is synchronous: counters, queues and the open partition clear, config
// returns to target 65536 and min rows 1.
// full follows the row-end queue; it only fills while parts wait on pop.
`default_nettype none
module ndjson_row_partitioner
  import ndjp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_buffer,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [OUT_BITS-1:0]          part_offset,
  output logic [OUT_BITS-1:0]          part_length,
  output logic [OUT_BITS-1:0]          first_row,
  output logic [OUT_BITS-1:0]          end_row,
  output logic                         final_part,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data
);

  localparam int EVW = 2 * COUNT_BITS + 1;

  logic           ev_push;
  logic           ev_full;
  logic [EVW-1:0] ev_in;
  logic           ev_pop;
  logic           ev_empty;
  logic [EVW-1:0] ev_out;
  logic           res_push;
  logic           res_full;
  part_res_t      res_in;
  part_res_t      res_out;

  ndjp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .ev_push       (ev_push),
    .ev_full       (ev_full),
    .ev_word       (ev_in)
  );

  ndjp_fifo #(.WIDTH(EVW), .DEPTH(EVQ_DEPTH)) u_evq (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .full  (ev_full),
    .din   (ev_in),
    .pop   (ev_pop),
    .empty (ev_empty),
    .dout  (ev_out)
  );

  ndjp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_empty  (ev_empty),
    .ev_word   (ev_out),
    .ev_pop    (ev_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_in)
  );

  ndjp_fifo #(.WIDTH($bits(part_res_t)), .DEPTH(RESQ_DEPTH)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign part_offset = res_out.part_offset;
  assign part_length = res_out.part_length;
  assign first_row   = res_out.first_row;
  assign end_row     = res_out.end_row;
  assign final_part  = res_out.final_part;

endmodule
`default_nettype wire
